/* src/chebyshev_2d_series_eval_core_macros.svh */
// Assertion helpers shared by the core.
`ifndef CHEBYSHEV_2D_SERIES_EVAL_CORE_MACROS_SVH
`define CHEBYSHEV_2D_SERIES_EVAL_CORE_MACROS_SVH

// Same-cycle implication, reset disabled.
`define C2D_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, reset disabled.
`define C2D_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

/* src/cheb2d_pkg.sv */
`default_nettype none
package cheb2d_pkg;

    localparam int STORE_SIDE = 16;
    localparam int STORE_DEPTH = STORE_SIDE * STORE_SIDE;

    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_EVAL = 1'b1;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_Y_BAD = 2'd1;
    localparam logic [1:0] STATUS_X_BAD = 2'd2;

    localparam logic [2:0] CFG_DEG_X   = 3'd0;
    localparam logic [2:0] CFG_DEG_Y   = 3'd1;
    localparam logic [2:0] CFG_X_LO    = 3'd2;
    localparam logic [2:0] CFG_X_HI    = 3'd3;
    localparam logic [2:0] CFG_Y_LO    = 3'd4;
    localparam logic [2:0] CFG_Y_HI    = 3'd5;
    localparam logic [2:0] CFG_Y_POINT = 3'd6;

    localparam logic signed [63:0] INT64_MAX = 64'sh7fff_ffff_ffff_ffff;
    localparam logic signed [63:0] INT64_MIN = 64'sh8000_0000_0000_0000;
    localparam logic signed [63:0] INT32_MAX_W = 64'sh0000_0000_7fff_ffff;
    localparam logic signed [63:0] INT32_MIN_W = 64'shffff_ffff_8000_0000;
    localparam logic signed [63:0] ONE_Q30 = 64'sh0000_0000_4000_0000;
    localparam logic [64:0] MAG_TOP = 65'h0_8000_0000_0000_0000;

    typedef struct packed {
        logic               req_type;
        logic [3:0]         coef_row;
        logic [3:0]         coef_col;
        logic signed [31:0] coef_value;
        logic signed [31:0] x_value;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] series_value;
        logic [1:0]         status;
        logic               saturated;
    } out_item_t;

    typedef struct packed {
        logic start;
        logic narrow;
    } mul_req_t;

    typedef struct packed {
        logic done;
        logic sat;
    } mul_rsp_t;

    // Signed value from sign and magnitude; top bit of the result flags a clip.
    function automatic logic [64:0] from_mag(input logic neg, input logic [64:0] m);
        logic [64:0] r;
        if (!neg) begin
            r = (m >= MAG_TOP) ? {1'b1, INT64_MAX} : {1'b0, m[63:0]};
        end else if (m > MAG_TOP) begin
            r = {1'b1, INT64_MIN};
        end else begin
            r = {1'b0, 64'(-m[63:0])};
        end
        return r;
    endfunction

    function automatic logic [64:0] sat_add(input logic signed [63:0] a,
                                            input logic signed [63:0] b);
        logic signed [64:0] s;
        logic [64:0] r;
        s = 65'(a) + 65'(b);
        if (s[64] != s[63]) begin
            r = s[64] ? {1'b1, INT64_MIN} : {1'b1, INT64_MAX};
        end else begin
            r = {1'b0, s[63:0]};
        end
        return r;
    endfunction

    function automatic logic [64:0] sat_sub(input logic signed [63:0] a,
                                            input logic signed [63:0] b);
        logic signed [64:0] s;
        logic [64:0] r;
        s = 65'(a) - 65'(b);
        if (s[64] != s[63]) begin
            r = s[64] ? {1'b1, INT64_MIN} : {1'b1, INT64_MAX};
        end else begin
            r = {1'b0, s[63:0]};
        end
        return r;
    endfunction

endpackage
`default_nettype wire

/* src/chebyshev_2d_series_eval_core.sv */
// Evaluate requests run on the one shared Q30 multiplier and a one-bit-a-cycle divider
//   (65 steps per map).
// Bad range: no arithmetic, straight to the result state. Load request: stored, no result.
// Throughput: one request in flight; a waiting result does not hold the input side.
// Reset: synchronous, aresetn low, restores control and config state; coefficients are kept.
`default_nettype none
`include "chebyshev_2d_series_eval_core_macros.svh"
module chebyshev_2d_series_eval_core #(
    parameter int MAX_DEG_X = 15,
    parameter int MAX_DEG_Y = 15
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    // request channel
    input  wire logic                   s_valid,
    output logic                        s_ready,
    input  wire cheb2d_pkg::in_item_t   s_data,
    // result channel
    output logic                        m_valid,
    input  wire logic                   m_ready,
    output cheb2d_pkg::out_item_t       m_data,
    // configuration writes
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [2:0]             cfg_index,
    input  wire logic [31:0]            cfg_data
);

    typedef enum logic [11:0] {
        S_IDLE    = 12'b0000_0000_0001,
        S_MAP_SET = 12'b0000_0000_0010,
        S_DIV     = 12'b0000_0000_0100,
        S_MAP_END = 12'b0000_0000_1000,
        S_REC     = 12'b0000_0001_0000,
        S_TMUL    = 12'b0000_0010_0000,
        S_RD      = 12'b0000_0100_0000,
        S_RDW     = 12'b0000_1000_0000,
        S_RMUL    = 12'b0001_0000_0000,
        S_XST     = 12'b0010_0000_0000,
        S_XMUL    = 12'b0100_0000_0000,
        S_FIN     = 12'b1000_0000_0000
    } state_t;

    state_t state_reg;

    // configuration registers
    logic [3:0]         deg_x_reg, deg_y_reg;
    logic signed [31:0] x_lo_reg, x_hi_reg, y_lo_reg, y_hi_reg, y_point_reg;

    // per-request working state
    logic signed [31:0] x_reg;
    logic [1:0]         status_reg;
    logic               sat_reg;
    logic               phase_reg;      // low: x side, high: y side
    logic [31:0]        div_rem_reg, div_d_reg;
    logic [64:0]        div_quo_reg;
    logic [6:0]         div_cnt_reg;
    logic               div_neg_reg;
    logic signed [63:0] t_reg, prev1_reg, prev2_reg;
    logic [4:0]         k_reg;
    logic signed [63:0] tx_reg [cheb2d_pkg::STORE_SIDE];
    logic signed [63:0] ty_reg [cheb2d_pkg::STORE_SIDE];
    logic [3:0]         i_reg, j_reg;
    logic signed [63:0] row_reg, sum_reg;

    logic                  m_valid_reg;
    cheb2d_pkg::out_item_t m_data_reg;

    // shared multiplier
    cheb2d_pkg::mul_req_t mul_req;
    cheb2d_pkg::mul_rsp_t mul_rsp;
    logic signed [63:0]   mul_a, mul_b, mul_res;

    // coefficient store
    logic        ram_we;
    logic [7:0]  ram_waddr, ram_raddr;
    logic [31:0] ram_rdata;

    logic [3:0]         kx, ky, n_cur;
    logic               s_acc, x_bad, y_bad, range_ok;
    logic signed [31:0] map_p, map_lo, map_hi;
    logic signed [34:0] map_num;
    logic signed [32:0] map_diff;
    logic [33:0]        map_n;
    logic [64:0]        map_dvd;
    logic [32:0]        div_shift;
    logic               div_ge;
    logic [64:0]        map_fm;
    logic signed [63:0] dbl_val;
    logic               dbl_sat;
    logic [64:0]        rec_new, row_new, sum_new;
    logic signed [63:0] term_row, term_sum;
    logic               out_free;
    logic               mul_wait, eval_bad_acc;

    // Clamp degrees to the build limits.
    always_comb begin
        kx = (32'(deg_x_reg) > MAX_DEG_X) ? 4'(MAX_DEG_X) : deg_x_reg;
        ky = (32'(deg_y_reg) > MAX_DEG_Y) ? 4'(MAX_DEG_Y) : deg_y_reg;
        n_cur = phase_reg ? ky : kx;
    end

    assign s_ready   = (state_reg == S_IDLE);
    assign s_acc     = s_valid && s_ready;
    assign cfg_ready = 1'b1;

    always_comb begin
        x_bad = (x_lo_reg >= x_hi_reg) || (s_data.x_value < x_lo_reg)
                || (s_data.x_value > x_hi_reg);
        y_bad = (y_lo_reg >= y_hi_reg) || (y_point_reg < y_lo_reg)
                || (y_point_reg > y_hi_reg);
        range_ok = (x_lo_reg < x_hi_reg) && (y_lo_reg < y_hi_reg);
    end

    // Map onto [-1,1]: q = (|2p-(hi+lo)|*2^30 + floor(d/2)) / d, d = hi-lo.
    always_comb begin
        map_p    = phase_reg ? y_point_reg : x_reg;
        map_lo   = phase_reg ? y_lo_reg : x_lo_reg;
        map_hi   = phase_reg ? y_hi_reg : x_hi_reg;
        map_num  = (35'(map_p) <<< 1) - (35'(map_hi) + 35'(map_lo));
        map_n    = map_num[34] ? 34'(-map_num) : map_num[33:0];
        map_diff = 33'(map_hi) - 33'(map_lo);
        map_dvd  = 65'({map_n, 30'd0}) + 65'(map_diff[31:1]);
        div_shift = {div_rem_reg, div_quo_reg[64]};
        div_ge    = div_shift >= {1'b0, div_d_reg};
        map_fm    = cheb2d_pkg::from_mag(div_neg_reg, div_quo_reg);
    end

    // Recurrence tail: 2*m - T(k-2), each step clipped.
    always_comb begin
        dbl_sat = mul_res[63] != mul_res[62];
        if (dbl_sat) begin
            dbl_val = mul_res[63] ? cheb2d_pkg::INT64_MIN : cheb2d_pkg::INT64_MAX;
        end else begin
            dbl_val = mul_res <<< 1;
        end
        rec_new  = cheb2d_pkg::sat_sub(dbl_val, prev2_reg);
        term_row = (j_reg == 4'd0) ? (mul_res >>> 1) : mul_res;
        row_new  = cheb2d_pkg::sat_add(row_reg, term_row);
        term_sum = (i_reg == 4'd0) ? (mul_res >>> 1) : mul_res;
        sum_new  = cheb2d_pkg::sat_add(sum_reg, term_sum);
    end

    // Drive the shared multiplier from the sequencer.
    always_comb begin
        mul_req.start  = 1'b0;
        mul_req.narrow = 1'b0;
        mul_a = t_reg;
        mul_b = prev1_reg;
        case (state_reg)
            S_REC: begin
                mul_req.start = (k_reg <= {1'b0, n_cur});
            end
            S_RDW: begin
                mul_req.start  = 1'b1;
                mul_req.narrow = 1'b1;
                mul_a = {{32{ram_rdata[31]}}, ram_rdata};
                mul_b = ty_reg[j_reg];
            end
            S_XST: begin
                mul_req.start = 1'b1;
                mul_a = tx_reg[i_reg];
                mul_b = row_reg;
            end
            default: begin
                mul_req.start = 1'b0;
            end
        endcase
    end

    assign ram_we    = s_acc && (s_data.req_type == cheb2d_pkg::REQ_LOAD);
    assign ram_waddr = {s_data.coef_row, s_data.coef_col};
    assign ram_raddr = {i_reg, j_reg};

    assign out_free = !m_valid_reg || m_ready;

    // Configuration writes; indexes beyond the list drop silently.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            deg_x_reg   <= 4'd0;
            deg_y_reg   <= 4'd0;
            x_lo_reg    <= -32'sd65536;
            x_hi_reg    <= 32'sd65536;
            y_lo_reg    <= -32'sd65536;
            y_hi_reg    <= 32'sd65536;
            y_point_reg <= 32'sd0;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                cheb2d_pkg::CFG_DEG_X:   deg_x_reg   <= cfg_data[3:0];
                cheb2d_pkg::CFG_DEG_Y:   deg_y_reg   <= cfg_data[3:0];
                cheb2d_pkg::CFG_X_LO:    x_lo_reg    <= cfg_data;
                cheb2d_pkg::CFG_X_HI:    x_hi_reg    <= cfg_data;
                cheb2d_pkg::CFG_Y_LO:    y_lo_reg    <= cfg_data;
                cheb2d_pkg::CFG_Y_HI:    y_hi_reg    <= cfg_data;
                cheb2d_pkg::CFG_Y_POINT: y_point_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Sequencer and datapath.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            // drop a taken result unless a new one lands in the same cycle
            if (m_valid_reg && m_ready && (state_reg != S_FIN)) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (s_acc && s_data.req_type == cheb2d_pkg::REQ_EVAL) begin
                        x_reg      <= s_data.x_value;
                        status_reg <= x_bad ? cheb2d_pkg::STATUS_X_BAD :
                                      (y_bad ? cheb2d_pkg::STATUS_Y_BAD :
                                       cheb2d_pkg::STATUS_OK);
                        sat_reg    <= 1'b0;
                        sum_reg    <= '0;
                        phase_reg  <= 1'b0;
                        state_reg  <= range_ok ? S_MAP_SET : S_FIN;
                    end
                end
                S_MAP_SET: begin
                    div_quo_reg <= map_dvd;
                    div_rem_reg <= '0;
                    div_d_reg   <= map_diff[31:0];
                    div_neg_reg <= map_num[34];
                    div_cnt_reg <= 7'd65;
                    state_reg   <= S_DIV;
                end
                S_DIV: begin
                    // one quotient bit a cycle, restoring
                    div_rem_reg <= div_ge ? 32'(div_shift - {1'b0, div_d_reg})
                                          : div_shift[31:0];
                    div_quo_reg <= {div_quo_reg[63:0], div_ge};
                    div_cnt_reg <= div_cnt_reg - 7'd1;
                    if (div_cnt_reg == 7'd1) begin
                        state_reg <= S_MAP_END;
                    end
                end
                S_MAP_END: begin
                    sat_reg   <= sat_reg | map_fm[64];
                    t_reg     <= map_fm[63:0];
                    prev2_reg <= cheb2d_pkg::ONE_Q30;
                    prev1_reg <= map_fm[63:0];
                    k_reg     <= 5'd2;
                    if (phase_reg) begin
                        ty_reg[0] <= cheb2d_pkg::ONE_Q30;
                        ty_reg[1] <= map_fm[63:0];
                    end else begin
                        tx_reg[0] <= cheb2d_pkg::ONE_Q30;
                        tx_reg[1] <= map_fm[63:0];
                    end
                    state_reg <= S_REC;
                end
                S_REC: begin
                    if (k_reg > {1'b0, n_cur}) begin
                        if (phase_reg) begin
                            i_reg     <= 4'd0;
                            j_reg     <= 4'd0;
                            row_reg   <= '0;
                            state_reg <= S_RD;
                        end else begin
                            phase_reg <= 1'b1;
                            state_reg <= S_MAP_SET;
                        end
                    end else begin
                        state_reg <= S_TMUL;
                    end
                end
                S_TMUL: begin
                    if (mul_rsp.done) begin
                        sat_reg   <= sat_reg | mul_rsp.sat | dbl_sat | rec_new[64];
                        if (phase_reg) begin
                            ty_reg[k_reg[3:0]] <= rec_new[63:0];
                        end else begin
                            tx_reg[k_reg[3:0]] <= rec_new[63:0];
                        end
                        prev2_reg <= prev1_reg;
                        prev1_reg <= rec_new[63:0];
                        k_reg     <= k_reg + 5'd1;
                        state_reg <= S_REC;
                    end
                end
                S_RD: begin
                    state_reg <= S_RDW;
                end
                S_RDW: begin
                    state_reg <= S_RMUL;
                end
                S_RMUL: begin
                    if (mul_rsp.done) begin
                        sat_reg <= sat_reg | mul_rsp.sat | row_new[64];
                        row_reg <= row_new[63:0];
                        if (j_reg == ky) begin
                            state_reg <= S_XST;
                        end else begin
                            j_reg     <= j_reg + 4'd1;
                            state_reg <= S_RD;
                        end
                    end
                end
                S_XST: begin
                    state_reg <= S_XMUL;
                end
                S_XMUL: begin
                    if (mul_rsp.done) begin
                        sat_reg <= sat_reg | mul_rsp.sat | sum_new[64];
                        sum_reg <= sum_new[63:0];
                        if (i_reg == kx) begin
                            state_reg <= S_FIN;
                        end else begin
                            i_reg     <= i_reg + 4'd1;
                            j_reg     <= 4'd0;
                            row_reg   <= '0;
                            state_reg <= S_RD;
                        end
                    end
                end
                S_FIN: begin
                    // hold until the output register is free, then clip to 32 bits
                    if (out_free) begin
                        m_data_reg.status <= status_reg;
                        if (sum_reg > cheb2d_pkg::INT32_MAX_W) begin
                            m_data_reg.series_value <= 32'sh7fff_ffff;
                            m_data_reg.saturated    <= 1'b1;
                        end else if (sum_reg < cheb2d_pkg::INT32_MIN_W) begin
                            m_data_reg.series_value <= 32'sh8000_0000;
                            m_data_reg.saturated    <= 1'b1;
                        end else begin
                            m_data_reg.series_value <= sum_reg[31:0];
                            m_data_reg.saturated    <= sat_reg;
                        end
                        m_valid_reg <= 1'b1;
                        state_reg   <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    cheb2d_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (mul_req),
        .a_in    (mul_a),
        .b_in    (mul_b),
        .rsp     (mul_rsp),
        .result  (mul_res)
    );

    cheb2d_ram #(
        .WIDTH (32),
        .DEPTH (cheb2d_pkg::STORE_DEPTH)
    ) u_coef_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (s_data.coef_value),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign mul_wait = (state_reg == S_TMUL) || (state_reg == S_RMUL)
                      || (state_reg == S_XMUL);
    assign eval_bad_acc = s_acc && (s_data.req_type == cheb2d_pkg::REQ_EVAL) && !range_ok;

    // A multiplier answer lands only where the sequencer waits for one.
    `C2D_ASSERT_IMP(a_mul_done_wait, aclk, aresetn, mul_rsp.done, mul_wait, "mul result off wait")
    // An empty range skips all arithmetic.
    `C2D_ASSERT_NXT(a_bad_range_fin, aclk, aresetn, eval_bad_acc, state_reg == S_FIN, "empty range")
    // The divider never runs past its last step.
    `C2D_ASSERT_IMP(a_div_count, aclk, aresetn, state_reg == S_DIV, div_cnt_reg != 7'd0, "div count")

endmodule
`default_nettype wire

/* src/cheb2d_ram.sv */
`default_nettype none
module cheb2d_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

/* src/cheb2d_mul.sv */
`default_nettype none
// Q30 product, 32x32 partial products one per cycle, then round and clip.
module cheb2d_mul (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire cheb2d_pkg::mul_req_t      req,
    input  wire logic signed [63:0]        a_in,
    input  wire logic signed [63:0]        b_in,
    output cheb2d_pkg::mul_rsp_t           rsp,
    output logic signed [63:0]             result
);

    logic [63:0]  mag_a_reg, mag_b_reg;
    logic         neg_reg, narrow_reg;
    logic [127:0] acc_reg;
    logic [1:0]   part_reg;
    logic         busy_reg, rnd_reg, done_reg, sat_reg;
    logic [63:0]  res_reg;

    logic [31:0]  a_part, b_part;
    logic [63:0]  prod;
    logic [127:0] prod_sh;
    logic [127:0] rnd_sum;
    logic [64:0]  fm;

    always_comb begin
        a_part = part_reg[1] ? mag_a_reg[63:32] : mag_a_reg[31:0];
        b_part = part_reg[0] ? mag_b_reg[63:32] : mag_b_reg[31:0];
        prod = 64'(a_part) * 64'(b_part);
        case (part_reg)
            2'd0:    prod_sh = {64'd0, prod};
            2'd3:    prod_sh = {prod, 64'd0};
            default: prod_sh = {32'd0, prod, 32'd0};
        endcase
        rnd_sum = acc_reg + (128'd1 << 29);
        fm = cheb2d_pkg::from_mag(neg_reg, {1'b0, rnd_sum[93:30]});
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            rnd_reg  <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            if (req.start) begin
                mag_a_reg  <= a_in[63] ? 64'(-a_in) : a_in;
                mag_b_reg  <= b_in[63] ? 64'(-b_in) : b_in;
                neg_reg    <= a_in[63] ^ b_in[63];
                narrow_reg <= req.narrow;
                acc_reg    <= '0;
                part_reg   <= 2'd0;
                busy_reg   <= 1'b1;
                done_reg   <= 1'b0;
            end else if (busy_reg) begin
                acc_reg  <= acc_reg + prod_sh;
                part_reg <= part_reg + 2'd1;
                done_reg <= 1'b0;
                // narrow operand: high half of a is zero, drop those parts
                if (part_reg == 2'd3 || (narrow_reg && part_reg == 2'd1)) begin
                    busy_reg <= 1'b0;
                    rnd_reg  <= 1'b1;
                end
            end else if (rnd_reg) begin
                rnd_reg  <= 1'b0;
                done_reg <= 1'b1;
                if (|rnd_sum[127:94]) begin
                    sat_reg <= 1'b1;
                    res_reg <= neg_reg ? cheb2d_pkg::INT64_MIN : cheb2d_pkg::INT64_MAX;
                end else begin
                    sat_reg <= fm[64];
                    res_reg <= fm[63:0];
                end
            end else begin
                done_reg <= 1'b0;
            end
        end
    end

    assign rsp.done = done_reg;
    assign rsp.sat  = sat_reg;
    assign result   = res_reg;

endmodule
`default_nettype wire

/* verif/tb_chebyshev_2d_series_eval_core.sv */
`timescale 1ns / 1ps
`default_nettype none

class cheb2d_scoreboard;
    logic signed [31:0]    coef [cheb2d_pkg::STORE_DEPTH];
    logic [3:0]            deg_x, deg_y;
    longint                x_lo, x_hi, y_lo, y_hi, y_point;
    bit                    clipped;
    cheb2d_pkg::out_item_t pending_results [$];
    int                    fails;

    function new();
        deg_x = 0; deg_y = 0;
        x_lo = -65536; x_hi = 65536;
        y_lo = -65536; y_hi = 65536;
        y_point = 0;
        fails = 0;
        foreach (coef[k]) coef[k] = '0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [31:0] d);
        case (idx)
            cheb2d_pkg::CFG_DEG_X:   deg_x = d[3:0];
            cheb2d_pkg::CFG_DEG_Y:   deg_y = d[3:0];
            cheb2d_pkg::CFG_X_LO:    x_lo = longint'($signed(d));
            cheb2d_pkg::CFG_X_HI:    x_hi = longint'($signed(d));
            cheb2d_pkg::CFG_Y_LO:    y_lo = longint'($signed(d));
            cheb2d_pkg::CFG_Y_HI:    y_hi = longint'($signed(d));
            cheb2d_pkg::CFG_Y_POINT: y_point = longint'($signed(d));
            default: ;
        endcase
    endfunction

    function logic [63:0] mag(longint a);
        return (a < 0) ? 64'(-a) : 64'(a);
    endfunction

    function longint signed_from_mag(bit neg, logic [63:0] m);
        if (!neg) begin
            if (m[63]) begin
                clipped = 1;
                return cheb2d_pkg::INT64_MAX;
            end
            return longint'(m);
        end
        if (m > 64'h8000_0000_0000_0000) begin
            clipped = 1;
            return cheb2d_pkg::INT64_MIN;
        end
        return longint'(-m);
    endfunction

    function longint add_clip(longint a, longint b);
        logic signed [64:0] s;
        s = 65'(a) + 65'(b);
        if (s > 65'(cheb2d_pkg::INT64_MAX)) begin
            clipped = 1;
            return cheb2d_pkg::INT64_MAX;
        end
        if (s < 65'(cheb2d_pkg::INT64_MIN)) begin
            clipped = 1;
            return cheb2d_pkg::INT64_MIN;
        end
        return longint'(s[63:0]);
    endfunction

    function longint sub_clip(longint a, longint b);
        logic signed [64:0] s;
        s = 65'(a) - 65'(b);
        if (s > 65'(cheb2d_pkg::INT64_MAX)) begin
            clipped = 1;
            return cheb2d_pkg::INT64_MAX;
        end
        if (s < 65'(cheb2d_pkg::INT64_MIN)) begin
            clipped = 1;
            return cheb2d_pkg::INT64_MIN;
        end
        return longint'(s[63:0]);
    endfunction

    // Q30 product, rounded half away from zero on the magnitude
    function longint mul_q30(longint a, longint b);
        bit neg;
        logic [127:0] p;
        neg = (a < 0) != (b < 0);
        p = 128'(mag(a)) * 128'(mag(b)) + (128'd1 << 29);
        if ((p >> 94) != 0) begin
            clipped = 1;
            return neg ? cheb2d_pkg::INT64_MIN : cheb2d_pkg::INT64_MAX;
        end
        return signed_from_mag(neg, p[93:30]);
    endfunction

    function longint to_unit(longint p, longint lo, longint hi);
        longint num;
        logic [63:0] d, n, q, r, frac;
        num = 2 * p - (hi + lo);
        d = 64'(hi - lo);
        n = mag(num);
        q = n / d;
        r = n % d;
        frac = ((r << 30) + d / 2) / d;
        return signed_from_mag(num < 0, (q << 30) + frac);
    endfunction

    function void chebyshev_values(longint t, int n, ref longint tv [16]);
        tv[0] = cheb2d_pkg::ONE_Q30;
        if (n >= 1) tv[1] = t;
        for (int k = 2; k <= n; k++)
            tv[k] = sub_clip(add_clip(mul_q30(t, tv[k-1]), mul_q30(t, tv[k-1])), tv[k-2]);
    endfunction

    function void note_request(cheb2d_pkg::in_item_t it);
        longint tx [16], ty [16];
        longint x, sum, row, term;
        cheb2d_pkg::out_item_t res;
        int kx, ky;
        if (it.req_type == cheb2d_pkg::REQ_LOAD) begin
            coef[{it.coef_row, it.coef_col}] = it.coef_value;
            return;
        end
        x = longint'(it.x_value);
        clipped = 0;
        sum = 0;
        res.status = cheb2d_pkg::STATUS_OK;
        if (y_lo >= y_hi || y_point < y_lo || y_point > y_hi)
            res.status = cheb2d_pkg::STATUS_Y_BAD;
        if (x_lo >= x_hi || x < x_lo || x > x_hi)
            res.status = cheb2d_pkg::STATUS_X_BAD;
        if (x_lo < x_hi && y_lo < y_hi) begin
            kx = deg_x;
            ky = deg_y;
            chebyshev_values(to_unit(x, x_lo, x_hi), kx, tx);
            chebyshev_values(to_unit(y_point, y_lo, y_hi), ky, ty);
            for (int i = 0; i <= kx; i++) begin
                row = 0;
                for (int j = 0; j <= ky; j++) begin
                    term = mul_q30(longint'(coef[i*cheb2d_pkg::STORE_SIDE + j]), ty[j]);
                    if (j == 0) term = term >>> 1;
                    row = add_clip(row, term);
                end
                term = mul_q30(tx[i], row);
                if (i == 0) term = term >>> 1;
                sum = add_clip(sum, term);
            end
            if (sum > cheb2d_pkg::INT32_MAX_W) begin
                sum = cheb2d_pkg::INT32_MAX_W;
                clipped = 1;
            end
            if (sum < cheb2d_pkg::INT32_MIN_W) begin
                sum = cheb2d_pkg::INT32_MIN_W;
                clipped = 1;
            end
        end
        res.series_value = sum[31:0];
        res.saturated = clipped;
        pending_results.push_back(res);
    endfunction

    function void check_result(cheb2d_pkg::out_item_t got);
        cheb2d_pkg::out_item_t want;
        if (pending_results.size() == 0) begin
            $error("result with nothing pending: value %0d", got.series_value);
            fails++;
            return;
        end
        want = pending_results.pop_front();
        if (got.series_value !== want.series_value) begin
            $error("series_value: expected %0d, got %0d", want.series_value, got.series_value);
            fails++;
        end
        if (got.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            fails++;
        end
        if (got.saturated !== want.saturated) begin
            $error("saturated: expected %0d, got %0d", want.saturated, got.saturated);
            fails++;
        end
    endfunction
endclass

module tb_chebyshev_2d_series_eval_core;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    cheb2d_pkg::in_item_t  s_data = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    cheb2d_pkg::out_item_t m_data;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [2:0]            cfg_index = '0;
    logic [31:0]           cfg_data = '0;

    // idle percentages of the sender and the receiver for the current phase
    int send_idle_pct = 0;
    int recv_stall_pct = 0;

    cheb2d_scoreboard sb = new();

    chebyshev_2d_series_eval_core i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Stall the result side at random; re-decide every cycle.
    always @(posedge aclk) begin
        m_ready <= (recv_stall_pct == 0) ? 1'b1 : ($urandom_range(99) >= recv_stall_pct);
    end

    // Watch both channels; values seen here are the ones from before the edge.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) sb.note_request(s_data);
            if (m_valid && m_ready) sb.check_result(m_data);
        end
    end

    // Offer one request: idle first (valid low) if the phase asks for it, then hold
    // valid and the payload until the block takes the request.
    task automatic send_request(cheb2d_pkg::in_item_t it);
        if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
            while ($urandom_range(99) < send_idle_pct) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Drop valid and wait until every pending result has come back, then let the
    // block finish any load still in hand.
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.pending_results.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [31:0] d);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        do @(posedge aclk); while (!cfg_ready);
        sb.set_reg(idx, d);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    function automatic cheb2d_pkg::in_item_t load_request(logic [3:0] r, logic [3:0] c,
                                                          logic [31:0] v);
        cheb2d_pkg::in_item_t it;
        it = '0;
        it.req_type   = cheb2d_pkg::REQ_LOAD;
        it.coef_row   = r;
        it.coef_col   = c;
        it.coef_value = v;
        it.x_value    = $urandom;
        return it;
    endfunction

    function automatic cheb2d_pkg::in_item_t eval_request(logic [31:0] x);
        cheb2d_pkg::in_item_t it;
        it = '0;
        it.req_type   = cheb2d_pkg::REQ_EVAL;
        it.coef_row   = 4'($urandom);
        it.coef_col   = 4'($urandom);
        it.coef_value = $urandom;
        it.x_value    = x;
        return it;
    endfunction

    // Coefficients: mostly a few units in Q16.16, now and then anything at all.
    function automatic logic [31:0] rand_coef();
        int pick;
        pick = $urandom_range(99);
        if (pick < 70) return $signed($urandom) >>> $urandom_range(10, 14);
        if (pick < 80) return $urandom_range(1) ? 32'h7fff_ffff : 32'h8000_0000;
        return $urandom;
    endfunction

    // A point mostly inside [lo, hi], sometimes on an end or anywhere.
    function automatic logic [31:0] rand_point(longint lo, longint hi);
        int pick;
        longint span;
        pick = $urandom_range(99);
        if (hi > lo && pick < 70) begin
            span = hi - lo + 1;
            return 32'(lo + longint'({$urandom, $urandom} % span));
        end
        if (pick < 80) return 32'(lo);
        if (pick < 90) return 32'(hi);
        return $urandom;
    endfunction

    task automatic random_phase(int n_items, int deg_cap);
        longint a, b, lo, hi;
        logic [31:0] d [7];
        int order [7];
        int pick, sh, tmp;
        cheb2d_pkg::in_item_t it;
        d[cheb2d_pkg::CFG_DEG_X] = $urandom_range(deg_cap);
        d[cheb2d_pkg::CFG_DEG_Y] = $urandom_range(deg_cap);
        for (int axis = 0; axis < 2; axis++) begin
            pick = $urandom_range(99);
            sh = $urandom_range(0, 15);
            a = longint'($signed($urandom)) >>> sh;
            b = longint'($signed($urandom)) >>> sh;
            lo = (a < b) ? a : b;
            hi = (a < b) ? b : a;
            if (pick < 8) begin
                lo = -2147483648; hi = 2147483647;
            end else if (pick < 14) begin
                hi = lo;
            end else if (pick < 20) begin
                {lo, hi} = {hi, lo};
            end else if (lo == hi) begin
                hi = lo + 1;
            end
            if (axis == 0) begin
                d[cheb2d_pkg::CFG_X_LO] = 32'(lo); d[cheb2d_pkg::CFG_X_HI] = 32'(hi);
            end else begin
                d[cheb2d_pkg::CFG_Y_LO] = 32'(lo); d[cheb2d_pkg::CFG_Y_HI] = 32'(hi);
                d[cheb2d_pkg::CFG_Y_POINT] = rand_point(lo, hi);
            end
        end
        // write in a shuffled order so no register ordering is assumed
        for (int k = 0; k < 7; k++) order[k] = k;
        for (int k = 0; k < 7; k++) begin
            sh = $urandom_range(k, 6);
            tmp = order[k];
            order[k] = order[sh];
            order[sh] = tmp;
            write_reg(3'(order[k]), d[order[k]]);
        end
        for (int n = 0; n < n_items; n++) begin
            if ($urandom_range(99) < 30)
                it = load_request(4'($urandom), 4'($urandom), rand_coef());
            else
                it = eval_request(rand_point(sb.x_lo, sb.x_hi));
            send_request(it);
        end
        drain();
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Fill the whole store so that no evaluation reads an unwritten entry.
        for (int k = 0; k < cheb2d_pkg::STORE_DEPTH; k++)
            send_request(load_request(4'(k / cheb2d_pkg::STORE_SIDE),
                                      4'(k % cheb2d_pkg::STORE_SIDE), rand_coef()));

        // Directed, reset settings (degree 0, both ranges [-1, 1], y at 0).
        send_request(eval_request(32'hffff_0000));
        send_request(eval_request(32'h0001_0000));
        send_request(eval_request(32'h0000_0000));
        send_request(eval_request(32'h8000_0000));
        send_request(eval_request(32'h7fff_ffff));
        send_request(eval_request(32'hfffe_ffff));
        send_request(load_request(4'd0, 4'd0, 32'h7fff_ffff));
        send_request(eval_request(32'h0000_8000));
        send_request(load_request(4'd0, 4'd0, 32'h8000_0000));
        send_request(eval_request(32'hffff_8000));
        drain();

        // Directed: full degrees with extreme coefficients, then bad and empty ranges.
        write_reg(cheb2d_pkg::CFG_DEG_X, 32'd15);
        write_reg(cheb2d_pkg::CFG_DEG_Y, 32'd15);
        write_reg(cheb2d_pkg::CFG_Y_POINT, 32'h0001_0000);
        send_request(load_request(4'd15, 4'd15, 32'h7fff_ffff));
        send_request(eval_request(32'h0001_0000));
        send_request(eval_request(32'h0000_4000));
        send_request(eval_request(32'h0003_0000));
        drain();
        write_reg(cheb2d_pkg::CFG_Y_POINT, 32'h0002_0000);
        write_reg(cheb2d_pkg::CFG_DEG_X, 32'd1);
        write_reg(cheb2d_pkg::CFG_DEG_Y, 32'd2);
        send_request(eval_request(32'h0000_1000));
        drain();
        write_reg(cheb2d_pkg::CFG_X_LO, 32'h0001_0000);
        write_reg(cheb2d_pkg::CFG_X_HI, 32'h0001_0000);
        send_request(eval_request(32'h0001_0000));
        drain();
        write_reg(cheb2d_pkg::CFG_X_LO, 32'h8000_0000);
        write_reg(cheb2d_pkg::CFG_X_HI, 32'h7fff_ffff);
        write_reg(cheb2d_pkg::CFG_Y_LO, 32'h0000_0005);
        write_reg(cheb2d_pkg::CFG_Y_HI, 32'h0000_0004);
        send_request(eval_request(32'h8000_0000));
        send_request(eval_request(32'h7fff_ffff));
        drain();

        // Random phases, cycling through the idle patterns; one phase with degrees up to the full 15.
        for (int ph = 0; ph < 12; ph++) begin
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 83; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 83; end
                default: begin send_idle_pct = 37; recv_stall_pct = 37; end
            endcase
            if (ph == 5) random_phase(12, 15);
            else random_phase(60, 4);
        end

        send_idle_pct = 0;
        recv_stall_pct = 0;
        drain();
        repeat (50) @(posedge aclk);
        if (sb.fails == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    initial begin
        #200ms;
        $display("Verification failed");
        $finish;
    end

endmodule

`default_nettype wire
